// File: design/mf3_pkg.sv
// Package for the 3x3 RGB median filter: shared widths, codes and item types.
// No dependencies; imported by every module and the bench.
`default_nettype none

package mf3_pkg;

  localparam int ColW  = 12;
  localparam int HgtW  = 16;
  localparam int RowW  = HgtW + 1;
  localparam int CntW  = ColW + HgtW;
  localparam int ChanW = 8;
  localparam int TapN  = 9;
  localparam int ApbAw = 3;
  localparam int ApbDw = 32;

  localparam logic [ColW-1:0] WidthRst  = 12'd640;
  localparam logic [HgtW-1:0] HeightRst = 16'd480;

  localparam logic CmdPixel = 1'b0;
  localparam logic CmdFlush = 1'b1;

  localparam logic RegWidth  = 1'b0;
  localparam logic RegHeight = 1'b1;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } pix_t;

  typedef struct packed {
    logic             cmd;
    logic [ChanW-1:0] red_in;
    logic [ChanW-1:0] green_in;
    logic [ChanW-1:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [ChanW-1:0] red_out;
    logic [ChanW-1:0] green_out;
    logic [ChanW-1:0] blue_out;
    logic             frame_last;
  } out_item_t;

  typedef struct packed {
    logic [ColW-1:0] col;
    logic            up_en;
    logic            mid_en;
    pix_t            pix;
    logic            emit;
    logic            mask_l;
    logic            mask_r;
    logic            last;
  } acc_t;

  typedef struct packed {
    pix_t [TapN-1:0] taps;
    logic            last;
  } win_t;

endpackage

`default_nettype wire

// File: design/mf3_stream_if.sv
// Valid/ready stream channel carrying one payload item per request.
// Payload type is a parameter; used with the item types of mf3_pkg.
`default_nettype none

interface mf3_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: design/median_filter_3x3_rgb.sv
// Top level of the streaming 3x3 RGB median filter with APB configuration.
// Depends on mf3_pkg, mf3_stream_if, mf3_cfg_regs, mf3_ctrl, mf3_row_window, mf3_median9.
//
//   channel  dir  handshake           payload
//   in_i     in   valid/ready         cmd, red_in, green_in, blue_in
//   out_o    out  valid/ready         red_out, green_out, blue_out, frame_last
//   apb      in   psel/penable/pready image_width (0x0), image_height (0x4)
//
// One item per cycle sustained while out_o takes results; a result passes the s1,
// window, row-sort and output registers. Row memories are read in the accept cycle and
// written from the s1 register, with forwarding when consecutive requests hit the same column.
// Reset clears position counters, window and valid flags; row memories keep contents.
// A full output register not taken holds the whole pipeline and drops in_i.ready.
`default_nettype none

module median_filter_3x3_rgb import mf3_pkg::*; #(
  parameter int MaxWidth = 2048
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [ApbAw-1:0] paddr,
  input  wire logic [ApbDw-1:0] pwdata,
  output logic      [ApbDw-1:0] prdata,
  output logic                  pready,
  mf3_stream_if.sink            in_i,
  mf3_stream_if.source          out_o
);

  logic [ColW-1:0]             width;
  logic [HgtW-1:0]             height;
  logic                        en, accept;
  acc_t                        acc;
  logic                        win_valid;
  win_t                        win;
  logic [TapN-1:0][ChanW-1:0]  red_vals, green_vals, blue_vals;
  logic [ChanW-1:0]            red_med, green_med, blue_med;
  logic                        med_valid_q, med_last_q;
  logic                        out_valid_q;
  out_item_t                   out_q;
  in_item_t                    in_item;

  assign en         = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && en;
  assign in_i.ready = en;
  assign in_item    = in_i.payload;

  mf3_cfg_regs u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .width_o  (width),
    .height_o (height)
  );

  mf3_ctrl #(.MaxWidth(MaxWidth)) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_item),
    .width_i  (width),
    .height_i (height),
    .acc_o    (acc)
  );

  mf3_row_window #(.MaxWidth(MaxWidth)) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .acc_valid_i (accept),
    .acc_i       (acc),
    .win_valid_o (win_valid),
    .win_o       (win)
  );

  always_comb begin
    for (int t = 0; t < TapN; t++) begin
      red_vals[t]   = win.taps[t].red;
      green_vals[t] = win.taps[t].green;
      blue_vals[t]  = win.taps[t].blue;
    end
  end

  mf3_median9 u_med_red (
    .clk_i  (clk_i),
    .en_i   (en),
    .vals_i (red_vals),
    .med_o  (red_med)
  );

  mf3_median9 u_med_green (
    .clk_i  (clk_i),
    .en_i   (en),
    .vals_i (green_vals),
    .med_o  (green_med)
  );

  mf3_median9 u_med_blue (
    .clk_i  (clk_i),
    .en_i   (en),
    .vals_i (blue_vals),
    .med_o  (blue_med)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      med_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      med_valid_q <= win_valid;
      out_valid_q <= med_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      med_last_q       <= win.last;
      out_q.red_out    <= red_med;
      out_q.green_out  <= green_med;
      out_q.blue_out   <= blue_med;
      out_q.frame_last <= med_last_q;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

endmodule

`default_nettype wire

// File: design/mf3_cfg_regs.sv
// APB-style register file: image width and image height.
// Depends on mf3_pkg.
`default_nettype none

module mf3_cfg_regs import mf3_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [ApbAw-1:0] paddr,
  input  wire logic [ApbDw-1:0] pwdata,
  output logic      [ApbDw-1:0] prdata,
  output logic                  pready,
  output logic      [ColW-1:0]  width_o,
  output logic      [HgtW-1:0]  height_o
);

  logic [ColW-1:0] width_q;
  logic [HgtW-1:0] height_q;
  logic            wr_en;
  logic            reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthRst;
      height_q <= HeightRst;
    end else if (wr_en) begin
      unique case (reg_sel)
        RegWidth:  width_q  <= pwdata[ColW-1:0];
        RegHeight: height_q <= pwdata[HgtW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegWidth:  prdata = ApbDw'(width_q);
      RegHeight: prdata = ApbDw'(height_q);
      default:   prdata = '0;
    endcase
  end

  assign width_o  = width_q;
  assign height_o = height_q;

endmodule

`default_nettype wire

// File: design/mf3_ctrl.sv
// Raster position tracking: input column/row, output count, edge masks, frame end.
// Depends on mf3_pkg.
`default_nettype none

module mf3_ctrl import mf3_pkg::*; #(
  parameter int MaxWidth = 2048
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            accept_i,
  input  wire in_item_t        item_i,
  input  wire logic [ColW-1:0] width_i,
  input  wire logic [HgtW-1:0] height_i,
  output acc_t                 acc_o
);

  logic [ColW-1:0] in_col_q, in_col_d;
  logic [RowW-1:0] in_row_q, in_row_d;
  logic [CntW-1:0] out_cnt_q, out_cnt_d;

  logic [ColW-1:0] w_eff, col, ocol;
  logic [HgtW-1:0] h_eff;
  logic [RowW-1:0] row_a;
  logic [CntW-1:0] total;
  logic            wrap, row_in_frame, col_end, emit, last, up_en;

  function automatic logic [RowW-1:0] sat_inc(input logic [RowW-1:0] v);
    return (&v) ? v : v + RowW'(1);
  endfunction

  always_comb begin
    if (width_i == '0) begin
      w_eff = ColW'(1);
    end else if (32'(width_i) > MaxWidth) begin
      w_eff = ColW'(MaxWidth);
    end else begin
      w_eff = width_i;
    end
    h_eff = (height_i == '0) ? HgtW'(1) : height_i;
    total = CntW'(w_eff) * CntW'(h_eff);

    wrap  = (in_col_q >= w_eff);
    col   = wrap ? '0 : in_col_q;
    row_a = wrap ? sat_inc(in_row_q) : in_row_q;

    row_in_frame = (row_a < RowW'(h_eff));
    up_en        = (row_a >= RowW'(2));
    emit         = up_en || ((row_a == RowW'(1)) && (col != '0));
    ocol         = (col != '0) ? col - ColW'(1) : w_eff - ColW'(1);
    last         = emit && ((out_cnt_q + CntW'(1)) >= total);
    col_end      = ((col + ColW'(1)) == w_eff);

    acc_o.col    = col;
    acc_o.up_en  = up_en;
    acc_o.mid_en = (row_a != '0);
    acc_o.pix    = '0;
    if (item_i.cmd == CmdPixel && row_in_frame) begin
      acc_o.pix = '{red: item_i.red_in, green: item_i.green_in, blue: item_i.blue_in};
    end
    acc_o.emit   = emit;
    acc_o.mask_l = (ocol == '0);
    acc_o.mask_r = (ocol == w_eff - ColW'(1));
    acc_o.last   = last;

    in_col_d  = col_end ? '0 : col + ColW'(1);
    in_row_d  = col_end ? sat_inc(row_a) : row_a;
    out_cnt_d = out_cnt_q;
    if (last) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_cnt_d = '0;
    end else if (emit) begin
      out_cnt_d = out_cnt_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_cnt_q <= '0;
    end else if (accept_i) begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_cnt_q <= out_cnt_d;
    end
  end

endmodule

`default_nettype wire

// File: design/mf3_row_window.sv
// Two row memories with read-modify-write and forwarding, plus the 3x3 window.
// Depends on mf3_pkg; fed by mf3_ctrl, feeds mf3_median9.
`default_nettype none

module mf3_row_window import mf3_pkg::*; #(
  parameter int MaxWidth = 2048
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic en_i,
  input  wire logic acc_valid_i,
  input  wire acc_t acc_i,
  output logic      win_valid_o,
  output win_t      win_o
);

  localparam int MemAw = $clog2(MaxWidth);

  pix_t upper_mem  [MaxWidth];
  pix_t middle_mem [MaxWidth];

  logic [MemAw-1:0] rd_addr, wr_addr;
  logic             s1_valid_q;
  acc_t             s1_q;
  pix_t             up_rd_q, mid_rd_q;
  logic             fwd_q;
  pix_t             fwd_up_q, fwd_mid_q;
  pix_t             up, mid;
  pix_t [2:0]       new_col;
  pix_t [TapN-1:0]  win_q, win_shift, win_masked;
  logic             win_valid_q;
  win_t             win_out_q;

  assign rd_addr = MemAw'(acc_i.col);
  assign wr_addr = MemAw'(s1_q.col);

  always_comb begin
    up  = '0;
    mid = '0;
    if (s1_q.up_en) begin
      up = fwd_q ? fwd_up_q : up_rd_q;
    end
    if (s1_q.mid_en) begin
      mid = fwd_q ? fwd_mid_q : mid_rd_q;
    end
    new_col[0] = up;
    new_col[1] = mid;
    new_col[2] = s1_q.pix;
    for (int j = 0; j < 3; j++) begin
      win_shift[j*3 + 0] = win_q[j*3 + 1];
      win_shift[j*3 + 1] = win_q[j*3 + 2];
      win_shift[j*3 + 2] = new_col[j];
      win_masked[j*3 + 0] = s1_q.mask_l ? '0 : win_shift[j*3 + 0];
      win_masked[j*3 + 1] = win_shift[j*3 + 1];
      win_masked[j*3 + 2] = s1_q.mask_r ? '0 : win_shift[j*3 + 2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && acc_valid_i) begin
      up_rd_q  <= upper_mem[rd_addr];
      mid_rd_q <= middle_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && s1_valid_q) begin
      upper_mem[wr_addr]  <= mid;
      middle_mem[wr_addr] <= s1_q.pix;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
      win_valid_q <= 1'b0;
      win_q       <= '0;
    end else if (en_i) begin
      s1_valid_q  <= acc_valid_i;
      fwd_q       <= acc_valid_i && s1_valid_q && (acc_i.col == s1_q.col);
      win_valid_q <= s1_valid_q && s1_q.emit;
      if (s1_valid_q) begin
        win_q <= (s1_q.emit && s1_q.last) ? '0 : win_shift;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q            <= acc_i;
      fwd_up_q        <= mid;
      fwd_mid_q       <= s1_q.pix;
      win_out_q.taps  <= win_masked;
      win_out_q.last  <= s1_q.last;
    end
  end

  assign win_valid_o = win_valid_q;
  assign win_o       = win_out_q;

endmodule

`default_nettype wire

// File: design/mf3_median9.sv
// Median of nine 8-bit values: registered row sorts, then max/med/min and median of three.
// Depends on mf3_pkg.
`default_nettype none

module mf3_median9 import mf3_pkg::*; (
  input  wire logic                         clk_i,
  input  wire logic                         en_i,
  input  wire logic [TapN-1:0][ChanW-1:0]   vals_i,
  output logic      [ChanW-1:0]             med_o
);

  typedef logic [2:0][ChanW-1:0] trio_t;

  function automatic trio_t sort3(input logic [ChanW-1:0] a, b, c);
    logic [ChanW-1:0] lo, hi, m, t;
    trio_t            r;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c < lo) begin
      t  = lo;
      lo = c;
      m  = t;
    end else if (c < hi) begin
      m = c;
    end else begin
      m  = hi;
      hi = c;
    end
    r[0] = lo;
    r[1] = m;
    r[2] = hi;
    return r;
  endfunction

  trio_t [2:0]      rows_q;
  trio_t            lows, mids, highs;
  trio_t            lows_sorted, highs_sorted;
  trio_t            mids_sorted, finals;
  logic [ChanW-1:0] max_lo, min_hi;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) begin
        rows_q[j] <= sort3(vals_i[j*3], vals_i[j*3 + 1], vals_i[j*3 + 2]);
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      lows[j]  = rows_q[j][0];
      mids[j]  = rows_q[j][1];
      highs[j] = rows_q[j][2];
    end
    lows_sorted  = sort3(lows[0], lows[1], lows[2]);
    highs_sorted = sort3(highs[0], highs[1], highs[2]);
    max_lo       = lows_sorted[2];
    min_hi       = highs_sorted[0];
    mids_sorted  = sort3(mids[0], mids[1], mids[2]);
    finals       = sort3(max_lo, mids_sorted[1], min_hi);
    med_o        = finals[1];
  end

endmodule

`default_nettype wire

// File: bench/median_filter_3x3_rgb_tb.sv
// Self-checking bench for median_filter_3x3_rgb: APB register setup, random
// pixel frames on the input stream, medians predicted and compared in order.
// Depends on mf3_pkg, mf3_stream_if and the median_filter_3x3_rgb RTL.
`default_nettype none

module median_filter_3x3_rgb_tb;
  import mf3_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxW = 2048;

  logic             clk_i;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [ApbAw-1:0] paddr;
  logic [ApbDw-1:0] pwdata;
  logic [ApbDw-1:0] prdata;
  logic             pready;

  mf3_stream_if #(.payload_t(in_item_t))  in_if ();
  mf3_stream_if #(.payload_t(out_item_t)) out_if ();

  median_filter_3x3_rgb #(.MaxWidth(MaxW)) uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_if),
    .out_o   (out_if)
  );

  in_item_t    pixel_queue [$];
  out_item_t   medians_due [$];
  int unsigned n_sent;
  int unsigned n_taken;
  int unsigned n_fail;
  int          stall_pct = 18;

  logic [ColW-1:0] cfg_width  = WidthRst;
  logic [HgtW-1:0] cfg_height = HeightRst;

  pix_t        upper_line  [0:MaxW-1];
  pix_t        middle_line [0:MaxW-1];
  pix_t        win         [0:8];
  int unsigned in_col;
  int unsigned in_row;
  int unsigned out_cnt;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  function automatic int unsigned eff_width();
    if (cfg_width == '0) return 1;
    if (cfg_width > MaxW) return MaxW;
    return cfg_width;
  endfunction

  function automatic int unsigned eff_height();
    return (cfg_height == '0) ? 1 : cfg_height;
  endfunction

  function automatic logic [ChanW-1:0] mid_of_nine(input logic [8:0][ChanW-1:0] v);
    logic [ChanW-1:0] t;
    for (int i = 0; i < 8; i++) begin
      for (int j = 0; j < 8 - i; j++) begin
        if (v[j] > v[j+1]) begin
          t = v[j];
          v[j] = v[j+1];
          v[j+1] = t;
        end
      end
    end
    return v[4];
  endfunction

  // Count the requests still needed to reach the frame's last output.
  function automatic int unsigned items_to_close();
    int unsigned w, h, c, r, n, k;
    logic        emit;
    w = eff_width();
    h = eff_height();
    c = in_col;
    r = in_row;
    n = out_cnt;
    k = 0;
    while (1) begin
      if (c >= w) begin
        c = 0;
        r++;
      end
      emit = (r >= 2) || (r == 1 && c >= 1);
      k++;
      if (c + 1 >= w) begin
        c = 0;
        r++;
      end else begin
        c++;
      end
      if (emit) begin
        if (n + 1 >= w * h) return k;
        n++;
      end
    end
  endfunction

  task automatic median_step(input in_item_t it);
    int unsigned     w, h, col, ocol, idx;
    pix_t            px, up, mid, p;
    logic            emit;
    out_item_t       res;
    logic [8:0][7:0] vr, vg, vb;
    w = eff_width();
    h = eff_height();
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    col = in_col;
    px = '0;
    up = '0;
    mid = '0;
    if (it.cmd == CmdPixel && in_row < h) begin
      px.red   = it.red_in;
      px.green = it.green_in;
      px.blue  = it.blue_in;
    end
    if (in_row >= 2) up = upper_line[col];
    if (in_row >= 1) mid = middle_line[col];
    upper_line[col]  = mid;
    middle_line[col] = px;
    for (int j = 0; j < 3; j++) begin
      win[j*3]   = win[j*3+1];
      win[j*3+1] = win[j*3+2];
    end
    win[2] = up;
    win[5] = mid;
    win[8] = px;
    emit = (in_row >= 2) || (in_row == 1 && col >= 1);
    ocol = (col >= 1) ? col - 1 : w - 1;
    if (col + 1 >= w) begin
      in_col = 0;
      in_row++;
    end else begin
      in_col = col + 1;
    end
    if (emit) begin
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          idx = j * 3 + k;
          p = win[idx];
          if ((k == 0 && ocol == 0) || (k == 2 && ocol == w - 1)) p = '0;
          vr[idx] = p.red;
          vg[idx] = p.green;
          vb[idx] = p.blue;
        end
      end
      res.red_out   = mid_of_nine(vr);
      res.green_out = mid_of_nine(vg);
      res.blue_out  = mid_of_nine(vb);
      if (out_cnt + 1 >= w * h) begin
        res.frame_last = 1'b1;
        in_col = 0;
        in_row = 0;
        out_cnt = 0;
        foreach (win[i]) win[i] = '0;
      end else begin
        res.frame_last = 1'b0;
        out_cnt++;
      end
      medians_due = {medians_due, res};
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        median_step(in_if.payload);
        n_taken++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (pixel_queue.size() > 0 && $urandom_range(99) >= stall_pct) begin
          in_if.valid   <= 1'b1;
          in_if.payload <= pixel_queue.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    out_item_t got, want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        got = out_if.payload;
        if (medians_due.size() == 0) begin
          $error("result with no pending request: %h", got);
          n_fail++;
        end else begin
          want = medians_due.pop_front();
          if (got.red_out !== want.red_out) begin
            $error("red_out: expected %0d, got %0d", want.red_out, got.red_out);
            n_fail++;
          end
          if (got.green_out !== want.green_out) begin
            $error("green_out: expected %0d, got %0d", want.green_out, got.green_out);
            n_fail++;
          end
          if (got.blue_out !== want.blue_out) begin
            $error("blue_out: expected %0d, got %0d", want.blue_out, got.blue_out);
            n_fail++;
          end
          if (got.frame_last !== want.frame_last) begin
            $error("frame_last: expected %0d, got %0d", want.frame_last, got.frame_last);
            n_fail++;
          end
        end
      end
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic push_item(input logic cmd, input pix_t p);
    in_item_t it;
    it.cmd      = cmd;
    it.red_in   = p.red;
    it.green_in = p.green;
    it.blue_in  = p.blue;
    pixel_queue = {pixel_queue, it};
    n_sent++;
  endtask

  task automatic send_items(input int unsigned n, input int unsigned flush_pct);
    logic [31:0] r;
    repeat (n) begin
      r = $urandom;
      push_item(($urandom_range(99) < flush_pct) ? CmdFlush : CmdPixel, r[23:0]);
    end
  endtask

  // Hold until every request is taken and every median has come out.
  task automatic wait_idle();
    while (n_taken != n_sent || medians_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic sel, input logic [31:0] val);
    logic [31:0] word;
    word = $urandom;
    if (sel == RegWidth) word[ColW-1:0] = val[ColW-1:0];
    else word[HgtW-1:0] = val[HgtW-1:0];
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (sel == RegWidth) cfg_width = word[ColW-1:0];
    else cfg_height = word[HgtW-1:0];
  endtask

  initial begin
    logic [23:0] pats [0:8];
    int unsigned w, h, ew, eh, rand_start, phase;
    in_if.valid   = 1'b0;
    in_if.payload = '0;
    out_if.ready  = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    rst_ni  = 1'b0;
    n_sent  = 0;
    n_taken = 0;
    n_fail  = 0;
    in_col  = 0;
    in_row  = 0;
    out_cnt = 0;
    foreach (win[i]) win[i] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single pixel frame, width zero used as one
    apb_write(RegWidth, 0);
    apb_write(RegHeight, 1);
    push_item(CmdPixel, 24'hFFFFFF);
    push_item(CmdFlush, 24'h000000);
    push_item(CmdPixel, 24'hA5A5A5);
    wait_idle();

    // 3x3 frame with extremes, a flush inside and pixels past the last row
    apb_write(RegWidth, 3);
    apb_write(RegHeight, 3);
    pats[0] = 24'hFFFFFF; pats[1] = 24'h000000; pats[2] = 24'hFF00FF;
    pats[3] = 24'h00FF00; pats[4] = 24'hFFFFFF; pats[5] = 24'hFFFFFF;
    pats[6] = 24'h80FF01; pats[7] = 24'hFFFFFF; pats[8] = 24'h7F0080;
    for (int i = 0; i < 9; i++) push_item((i == 3) ? CmdFlush : CmdPixel, pats[i]);
    push_item(CmdFlush, 24'h000000);
    push_item(CmdPixel, 24'h123456);
    push_item(CmdFlush, 24'hFFFFFF);
    push_item(CmdPixel, 24'hFFFFFF);
    wait_idle();

    // widest row and tallest frame, then shrink mid-frame to close it
    apb_write(RegWidth, MaxW);
    apb_write(RegHeight, 16'hFFFF);
    push_item(CmdPixel, 24'hFFFFFF);
    push_item(CmdPixel, 24'h01FE80);
    wait_idle();
    apb_write(RegWidth, 12'hFFF);
    push_item(CmdPixel, 24'hFF00FF);
    wait_idle();
    apb_write(RegWidth, 2);
    apb_write(RegHeight, 2);
    send_items(items_to_close(), 20);
    wait_idle();

    rand_start = n_sent;
    phase = 0;
    while (n_sent - rand_start < 1900) begin
      phase++;
      stall_pct = (phase >= 6 && phase < 12) ? 0 : 18;
      wait_idle();
      w = $urandom_range(1, 8);
      if ($urandom_range(9) == 0) w = $urandom_range(9, 40);
      if ($urandom_range(15) == 0) w = 0;
      h = $urandom_range(1, 5);
      if ($urandom_range(15) == 0) h = 0;
      apb_write(RegWidth, w);
      apb_write(RegHeight, h);
      ew = eff_width();
      eh = eff_height();
      if ($urandom_range(4) == 0) begin
        send_items($urandom_range(1, ew * eh), 10);
        wait_idle();
        if ($urandom_range(1) == 0) apb_write(RegHeight, $urandom_range(0, 6));
        else apb_write(RegWidth, $urandom_range(0, eff_width()));
        send_items(items_to_close(), 10);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_items(ew * eh, 5);
          send_items(ew + 1, 50);
        end
      end
    end

    stall_pct = 18;
    wait_idle();
    if (n_fail == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
